@@ design/lgrs_pkg.sv @@
// Package with the item types, cell interface types and constants of the Life row stepper.
`timescale 1ns / 1ps

package lgrs_pkg;

  localparam int ROW_W = 64;
  localparam int CFG_W = 7;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int COUNT_W = 4;

  localparam logic [ADDR_W-1:0] ADDR_ACTIVE_WIDTH = 3'd0;
  localparam logic [CFG_W-1:0] ACTIVE_WIDTH_RESET = 7'd64;

  localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic [ROW_W-1:0] row_bits;
    logic last_row;
  } row_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] next_row;
    logic grid_done;
  } result_item_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic up;
    logic mid;
    logic down;
  } nbr_t;

endpackage

@@ design/lgrs_cell.sv @@
// One grid column: holds the two previous rows' bits and applies the B3/S23 rule.
`timescale 1ns / 1ps

module lgrs_cell
  import lgrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      en,
  input  logic      row_bit,
  input  logic      down_bit,
  input  nbr_t      left,
  input  nbr_t      right,
  output nbr_t      own,
  output logic      next_bit
);

  logic above;
  logic middle;
  logic [COUNT_W-1:0] n;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      above <= 1'b0;
      middle <= 1'b0;
    end else if (ctl.load) begin
      above <= ctl.shift ? middle : 1'b0;
      middle <= row_bit;
    end
  end

  assign own.up = above & en;
  assign own.mid = middle & en;
  assign own.down = down_bit;

  assign n = COUNT_W'(left.up) + COUNT_W'(left.mid) + COUNT_W'(left.down)
           + COUNT_W'(own.up) + COUNT_W'(own.down)
           + COUNT_W'(right.up) + COUNT_W'(right.mid) + COUNT_W'(right.down);

  assign next_bit = en & ((n == BIRTH_COUNT) | (own.mid & (n == SURVIVE_COUNT)));

endmodule

@@ design/life_generation_row_stepper.sv @@
// Top level of the Life row stepper: config register, column cells and result queue.
//
//   channel   dir  handshake              payload
//   row       in   row_valid / row_stall  row_item (row_bits, last_row)
//   res       out  res_valid / res_stall  res_item (next_row, grid_done)
//   apb       in   psel / penable / pwrite  paddr, pwdata, prdata
//
// A row item is taken every cycle unless row_stall is high; a row flagged last also gives a
// second, closing result, set by the single rule evaluation per column cell.
// Results are registered into a two-entry queue and leave from its head.
// Reset clears the held rows, the queue and sets the active width to 64.
// The row side stalls only while the queue is full or the closing result is pending.
`timescale 1ns / 1ps

module life_generation_row_stepper
  import lgrs_pkg::*;
#(
  parameter int MAX_WIDTH = 64
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                row_valid,
  output logic                row_stall,
  input  row_item_t           row_item,
  output logic                res_valid,
  input  logic                res_stall,
  output result_item_t        res_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [CFG_W-1:0] active_width;
  logic [CFG_W-1:0] eff_width;
  logic [ROW_W-1:0] col_en;
  logic [ROW_W-1:0] row_masked;
  logic [ROW_W-1:0] down_vec;
  logic [ROW_W-1:0] next_vec;

  logic row_seen;
  logic flush_pending;
  logic accept;
  logic flush_go;
  logic push;
  logic pop;
  cell_ctl_t ctl;

  result_item_t fifo_q [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  result_item_t push_item;

  nbr_t own_nb [MAX_WIDTH];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width <= ACTIVE_WIDTH_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_ACTIVE_WIDTH) begin
      active_width <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_ACTIVE_WIDTH) begin
      prdata[CFG_W-1:0] = active_width;
    end
  end

  always_comb begin
    if (active_width == '0) begin
      eff_width = CFG_W'(1);
    end else if (active_width > CFG_W'(MAX_WIDTH)) begin
      eff_width = CFG_W'(MAX_WIDTH);
    end else begin
      eff_width = active_width;
    end
  end

  always_comb begin
    for (int c = 0; c < ROW_W; c++) begin
      col_en[c] = (c < MAX_WIDTH) && (CFG_W'(c) < eff_width);
    end
  end

  assign row_masked = row_item.row_bits & col_en;
  assign down_vec = flush_pending ? '0 : row_masked;

  assign row_stall = flush_pending || (fill == 2'd2);
  assign accept = row_valid && !row_stall;
  assign flush_go = flush_pending && (fill != 2'd2);
  assign pop = res_valid && !res_stall;

  assign ctl.load = accept;
  assign ctl.shift = row_seen;
  assign ctl.clear = flush_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_seen <= 1'b0;
      flush_pending <= 1'b0;
    end else if (flush_go) begin
      row_seen <= 1'b0;
      flush_pending <= 1'b0;
    end else if (accept) begin
      row_seen <= 1'b1;
      flush_pending <= row_item.last_row;
    end
  end

  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
    nbr_t left_nb;
    nbr_t right_nb;
    if (c == 0) begin : g_lb
      assign left_nb = '0;
    end else begin : g_li
      assign left_nb = own_nb[c-1];
    end
    if (c == MAX_WIDTH - 1) begin : g_rb
      assign right_nb = '0;
    end else begin : g_ri
      assign right_nb = own_nb[c+1];
    end
    lgrs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .en       (col_en[c]),
      .row_bit  (row_masked[c]),
      .down_bit (down_vec[c]),
      .left     (left_nb),
      .right    (right_nb),
      .own      (own_nb[c]),
      .next_bit (next_vec[c])
    );
  end

  if (MAX_WIDTH < ROW_W) begin : g_pad
    assign next_vec[ROW_W-1:MAX_WIDTH] = '0;
  end

  assign push = (accept && row_seen) || flush_go;
  assign push_item.next_row = next_vec;
  assign push_item.grid_done = flush_go;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_q[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  assign res_valid = (fill != 2'd0);
  assign res_item = fifo_q[rd_ptr];

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("Result queue fill count out of range.");

  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && row_item.last_row) |=> flush_pending)
    else $error("Last row did not schedule the closing result.");

  a_flush_out: assert property (@(posedge clk) disable iff (rst) flush_go |=> res_valid)
    else $error("Closing result was not queued.");

  a_unused_cols: assert property (@(posedge clk) disable iff (rst)
    push |-> ((next_vec & ~col_en) == '0))
    else $error("Result has live cells beyond the active width.");

endmodule
